FILE: sv/guillotine_rect_allocator_unit_macros.svh
// Assertion macros shared by the checker of the rectangle allocator.
// No dependencies; included by files that carry concurrent assertions.
`ifndef GUILLOTINE_RECT_ALLOCATOR_UNIT_MACROS_SVH
`define GUILLOTINE_RECT_ALLOCATOR_UNIT_MACROS_SVH

// expr must never be true while out of reset
`define GRA_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define GRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/gra_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and controller/datapath interface structs of the allocator.
// No dependencies.
package gra_pkg;

    localparam int COORD_BITS         = 12;
    localparam int SIZE_BITS          = COORD_BITS + 1;
    localparam int AREA_BITS          = 2 * SIZE_BITS;
    localparam int DEF_MAX_FREE_RECTS = 64;
    localparam int CFG_IDX_BITS       = 1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [SIZE_BITS-1:0]  dim_t;
    typedef logic [SIZE_BITS:0]    ext_t;
    typedef logic [AREA_BITS-1:0]  area_t;

    localparam dim_t PAGE_RESET = dim_t'(1024);
    localparam dim_t PAGE_MAX   = dim_t'(1 << COORD_BITS);

    typedef struct packed {
        coord_t x;
        coord_t y;
        dim_t   w;
        dim_t   h;
    } rect_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_NO_FIT = 2'd1,
        STATUS_FULL   = 2'd2
    } status_t;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic    load_req;
        logic    load_rel;
        logic    load_b2;
        logic    clr_ptr;
        logic    inc_ptr;
        logic    ptr_best;
        logic    rd_cur;
        logic    rd_next;
        logic    best_mul;
        logic    best_cmp;
        logic    split;
        logic    pre_eval;
        logic    join_eval;
        logic    wr_shift;
        logic    dec_count;
        logic    append;
        logic    set_status;
        status_t status_code;
        logic    load_out;
    } gra_cmd_t;

    typedef struct packed {
        logic mode;
        logic req_zero;
        logic rel_ok;
        logic at_end;
        logic shift_end;
        logic list_full;
        logic found;
        logic b1_ne;
        logic b2_ne;
        logic pre_merged;
        logic join_hit;
        logic out_free;
    } gra_stat_t;

endpackage

FILE: sv/gra_datapath.sv
`timescale 1ns / 1ps
// Datapath: free-list memory, pointers, fit/area compare, split and merge logic.
// Depends on gra_pkg; driven by gra_ctrl through gra_cmd_t.
module gra_datapath
    import gra_pkg::*;
#(
    parameter int MAX_FREE_RECTS = DEF_MAX_FREE_RECTS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  dim_t                    cfg_data,
    output logic                    cfg_ready,
    input  logic                    in_mode,
    input  rect_t                   in_rect,
    input  gra_cmd_t                cmd,
    output gra_stat_t               stat,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              out_status,
    output coord_t                  out_x,
    output coord_t                  out_y
);

    localparam int IDX_W = $clog2(MAX_FREE_RECTS);
    localparam int CNT_W = $clog2(MAX_FREE_RECTS + 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FREE_RECTS);

    typedef struct packed {
        logic  hit;
        rect_t r;
    } join_t;

    function automatic dim_t clamp_page(dim_t v);
        dim_t res;
        res = v;
        if (v == '0) res = dim_t'(1);
        else if (v > PAGE_MAX) res = PAGE_MAX;
        return res;
    endfunction

    // first applicable edge join, same order as the merge rule
    function automatic join_t join_rects(rect_t b, rect_t e);
        ext_t  b_xe;
        ext_t  e_xe;
        ext_t  b_ye;
        ext_t  e_ye;
        logic  same_row;
        logic  same_col;
        join_t res;
        b_xe = ext_t'(b.x) + ext_t'(b.w);
        e_xe = ext_t'(e.x) + ext_t'(e.w);
        b_ye = ext_t'(b.y) + ext_t'(b.h);
        e_ye = ext_t'(e.y) + ext_t'(e.h);
        same_row = (b.y == e.y) && (b.h == e.h);
        same_col = (b.x == e.x) && (b.w == e.w);
        res.hit = 1'b1;
        res.r   = b;
        if (same_row && b_xe == ext_t'(e.x)) begin
            res.r.w = b.w + e.w;
        end
        else if (same_row && e_xe == ext_t'(b.x)) begin
            res.r.x = e.x;
            res.r.w = b.w + e.w;
        end
        else if (same_col && b_ye == ext_t'(e.y)) begin
            res.r.h = b.h + e.h;
        end
        else if (same_col && e_ye == ext_t'(b.y)) begin
            res.r.y = e.y;
            res.r.h = b.h + e.h;
        end
        else begin
            res.hit = 1'b0;
        end
        return res;
    endfunction

    rect_t            mem [MAX_FREE_RECTS];
    rect_t            mem_q;
    logic             hit0_reg;

    dim_t             pw_reg;
    dim_t             ph_reg;
    logic [CNT_W-1:0] count_reg;
    logic             ent0_reg;
    logic [CNT_W-1:0] ptr_reg;
    logic             found_reg;
    logic             out_valid_reg;

    logic             mode_reg;
    rect_t            req_reg;
    rect_t            cur_reg;
    rect_t            b2_reg;
    rect_t            box_reg;
    logic             b1_ne_reg;
    logic             b2_ne_reg;
    logic             pre_m_reg;
    logic [IDX_W-1:0] best_idx_reg;
    area_t            best_area_reg;
    area_t            area_reg;
    logic             fit_reg;
    status_t          status_reg;
    logic [1:0]       out_status_reg;
    coord_t           out_x_reg;
    coord_t           out_y_reg;

    rect_t            rd_val;
    rect_t            page_rect;
    logic [CNT_W-1:0] ptr_inc;
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] wa;
    logic [IDX_W-1:0] ra;
    rect_t            wd;
    join_t            jn1;
    join_t            jn2;
    dim_t             avail_w;
    dim_t             avail_h;
    rect_t            rel_rect;
    dim_t             dx;
    dim_t             dy;
    logic             wide;
    logic             cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    assign page_rect = '{x: '0, y: '0, w: pw_reg, h: ph_reg};
    assign rd_val    = hit0_reg ? page_rect : mem_q;
    assign ptr_inc   = ptr_reg + CNT_ONE;

    assign mem_we = cmd.wr_shift || cmd.append;
    assign mem_re = cmd.rd_cur || cmd.rd_next;
    assign wa     = cmd.append ? count_reg[IDX_W-1:0] : ptr_reg[IDX_W-1:0];
    assign wd     = cmd.append ? cur_reg : rd_val;
    assign ra     = cmd.rd_next ? ptr_inc[IDX_W-1:0] : ptr_reg[IDX_W-1:0];

    assign jn1 = join_rects(cur_reg, rd_val);
    assign jn2 = join_rects(b2_reg, rd_val);

    assign avail_w  = pw_reg - dim_t'(req_reg.x);
    assign avail_h  = ph_reg - dim_t'(req_reg.y);
    assign rel_rect = '{x: req_reg.x, y: req_reg.y,
                        w: (req_reg.w > avail_w) ? avail_w : req_reg.w,
                        h: (req_reg.h > avail_h) ? avail_h : req_reg.h};

    assign dx   = box_reg.w - req_reg.w;
    assign dy   = box_reg.h - req_reg.h;
    assign wide = dy < dx;

    always_comb
    begin
        stat.mode       = mode_reg;
        stat.req_zero   = (req_reg.w == '0) || (req_reg.h == '0);
        stat.rel_ok     = (req_reg.w != '0) && (req_reg.h != '0)
                          && (dim_t'(req_reg.x) < pw_reg) && (dim_t'(req_reg.y) < ph_reg);
        stat.at_end     = ptr_reg == count_reg;
        stat.shift_end  = ptr_inc == count_reg;
        stat.list_full  = count_reg == CNT_MAX;
        stat.found      = found_reg;
        stat.b1_ne      = b1_ne_reg;
        stat.b2_ne      = b2_ne_reg;
        stat.pre_merged = pre_m_reg;
        stat.join_hit   = jn1.hit;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // free-list storage, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wa] <= wd;
        end
        if (mem_re)
        begin
            mem_q    <= mem[ra];
            hit0_reg <= (ra == '0) && ent0_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg        <= PAGE_RESET;
            ph_reg        <= PAGE_RESET;
            count_reg     <= CNT_ONE;
            ent0_reg      <= 1'b1;
            ptr_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (cfg_index == CFG_PAGE_WIDTH) pw_reg <= clamp_page(cfg_data);
                if (cfg_index == CFG_PAGE_HEIGHT) ph_reg <= clamp_page(cfg_data);
                count_reg <= CNT_ONE;
                ent0_reg  <= 1'b1;
            end
            else
            begin
                if (mem_we && wa == '0) ent0_reg <= 1'b0;
                if (cmd.dec_count) count_reg <= count_reg - CNT_ONE;
                else if (cmd.append) count_reg <= count_reg + CNT_ONE;
            end

            if (cmd.clr_ptr) ptr_reg <= '0;
            else if (cmd.ptr_best) ptr_reg <= CNT_W'(best_idx_reg);
            else if (cmd.inc_ptr) ptr_reg <= ptr_inc;

            if (cmd.load_req) found_reg <= 1'b0;
            else if (cmd.best_cmp && fit_reg && (!found_reg || area_reg < best_area_reg))
                found_reg <= 1'b1;

            if (cmd.load_out) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            mode_reg   <= in_mode;
            req_reg    <= in_rect;
            status_reg <= STATUS_OK;
        end
        else if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
        end

        if (cmd.best_mul)
        begin
            area_reg <= area_t'(rd_val.w) * area_t'(rd_val.h);
            fit_reg  <= (rd_val.w >= req_reg.w) && (rd_val.h >= req_reg.h);
        end

        if (cmd.best_cmp && fit_reg && (!found_reg || area_reg < best_area_reg))
        begin
            best_idx_reg  <= ptr_reg[IDX_W-1:0];
            best_area_reg <= area_reg;
            box_reg       <= rd_val;
        end

        // guillotine cut along the longer leftover axis
        if (cmd.split)
        begin
            cur_reg   <= '{x: box_reg.x + req_reg.w[COORD_BITS-1:0], y: box_reg.y,
                           w: dx, h: wide ? box_reg.h : req_reg.h};
            b2_reg    <= '{x: box_reg.x, y: box_reg.y + req_reg.h[COORD_BITS-1:0],
                           w: wide ? req_reg.w : box_reg.w, h: dy};
            b1_ne_reg <= dx != '0;
            b2_ne_reg <= dy != '0;
            pre_m_reg <= 1'b0;
        end
        else if (cmd.load_rel)
        begin
            cur_reg <= rel_rect;
        end
        else if (cmd.load_b2)
        begin
            cur_reg <= b2_reg;
        end
        else if (cmd.join_eval && jn1.hit)
        begin
            cur_reg <= jn1.r;
        end

        if (cmd.pre_eval && ptr_reg != CNT_W'(best_idx_reg))
        begin
            pre_m_reg <= pre_m_reg || jn1.hit || jn2.hit;
        end

        if (cmd.load_out)
        begin
            out_status_reg <= status_reg;
            if (status_reg == STATUS_OK && mode_reg == MODE_ALLOC)
            begin
                out_x_reg <= box_reg.x;
                out_y_reg <= box_reg.y;
            end
            else
            begin
                out_x_reg <= '0;
                out_y_reg <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;

endmodule

FILE: sv/gra_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences scans, shifts, merges and appends.
// Depends on gra_pkg; commands gra_datapath.
module gra_ctrl
    import gra_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  gra_stat_t stat,
    output gra_cmd_t  cmd
);

    typedef enum logic [14:0] {
        ST_IDLE     = 15'b000000000000001,
        ST_DECODE   = 15'b000000000000010,
        ST_BEST_RD  = 15'b000000000000100,
        ST_BEST_MUL = 15'b000000000001000,
        ST_BEST_CMP = 15'b000000000010000,
        ST_SPLIT    = 15'b000000000100000,
        ST_PLAN     = 15'b000000001000000,
        ST_PRE_RD   = 15'b000000010000000,
        ST_PRE_EV   = 15'b000000100000000,
        ST_SHIFT_RD = 15'b000001000000000,
        ST_SHIFT_WR = 15'b000010000000000,
        ST_JOIN_RD  = 15'b000100000000000,
        ST_JOIN_EV  = 15'b001000000000000,
        ST_APPEND   = 15'b010000000000000,
        ST_DONE     = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   rm_best_reg, rm_best_next;
    logic   second_reg, second_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rm_best_reg <= 1'b0;
            second_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rm_best_reg <= rm_best_next;
            second_reg  <= second_next;
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.status_code = STATUS_OK;
        state_next   = state_reg;
        rm_best_next = rm_best_reg;
        second_next  = second_reg;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.mode == MODE_RELEASE)
                begin
                    if (stat.rel_ok)
                    begin
                        cmd.load_rel = 1'b1;
                        cmd.clr_ptr  = 1'b1;
                        second_next  = 1'b0;
                        state_next   = ST_JOIN_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (stat.req_zero)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STATUS_NO_FIT;
                    state_next      = ST_DONE;
                end
                else
                begin
                    cmd.clr_ptr = 1'b1;
                    state_next  = ST_BEST_RD;
                end
            end
            ST_BEST_RD:
            begin
                if (stat.at_end)
                begin
                    if (stat.found)
                    begin
                        state_next = ST_SPLIT;
                    end
                    else
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = STATUS_NO_FIT;
                        state_next      = ST_DONE;
                    end
                end
                else
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = ST_BEST_MUL;
                end
            end
            ST_BEST_MUL:
            begin
                cmd.best_mul = 1'b1;
                state_next   = ST_BEST_CMP;
            end
            ST_BEST_CMP:
            begin
                cmd.best_cmp = 1'b1;
                cmd.inc_ptr  = 1'b1;
                state_next   = ST_BEST_RD;
            end
            ST_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = ST_PLAN;
            end
            ST_PLAN:
            begin
                // a full list can only overflow if neither strip merges anywhere
                if (stat.list_full && stat.b1_ne && stat.b2_ne)
                begin
                    cmd.clr_ptr = 1'b1;
                    state_next  = ST_PRE_RD;
                end
                else
                begin
                    cmd.ptr_best = 1'b1;
                    rm_best_next = 1'b1;
                    state_next   = ST_SHIFT_RD;
                end
            end
            ST_PRE_RD:
            begin
                if (stat.at_end)
                begin
                    if (stat.pre_merged)
                    begin
                        cmd.ptr_best = 1'b1;
                        rm_best_next = 1'b1;
                        state_next   = ST_SHIFT_RD;
                    end
                    else
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = STATUS_FULL;
                        state_next      = ST_DONE;
                    end
                end
                else
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = ST_PRE_EV;
                end
            end
            ST_PRE_EV:
            begin
                cmd.pre_eval = 1'b1;
                cmd.inc_ptr  = 1'b1;
                state_next   = ST_PRE_RD;
            end
            ST_SHIFT_RD:
            begin
                if (stat.shift_end)
                begin
                    cmd.dec_count = 1'b1;
                    cmd.clr_ptr   = 1'b1;
                    if (rm_best_reg)
                    begin
                        rm_best_next = 1'b0;
                        if (stat.b1_ne)
                        begin
                            second_next = stat.b2_ne;
                            state_next  = ST_JOIN_RD;
                        end
                        else if (stat.b2_ne)
                        begin
                            cmd.load_b2 = 1'b1;
                            second_next = 1'b0;
                            state_next  = ST_JOIN_RD;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        state_next = ST_JOIN_RD;
                    end
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.inc_ptr  = 1'b1;
                state_next   = ST_SHIFT_RD;
            end
            ST_JOIN_RD:
            begin
                if (stat.at_end)
                begin
                    if (stat.list_full)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = STATUS_FULL;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_APPEND;
                    end
                end
                else
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = ST_JOIN_EV;
                end
            end
            ST_JOIN_EV:
            begin
                cmd.join_eval = 1'b1;
                if (stat.join_hit)
                begin
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    cmd.inc_ptr = 1'b1;
                    state_next  = ST_JOIN_RD;
                end
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
                if (second_reg)
                begin
                    cmd.load_b2 = 1'b1;
                    cmd.clr_ptr = 1'b1;
                    second_next = 1'b0;
                    state_next  = ST_JOIN_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/guillotine_rect_allocator_unit.sv
`timescale 1ns / 1ps
// Guillotine best-area-fit rectangle allocator for one texture page. It keeps
// an ordered free list in a single-port memory of MAX_FREE_RECTS entries and
// handles one transaction at a time. An allocate scans the list entry by
// entry (read, multiply, compare), then removes the chosen entry and inserts
// the non-empty cut strips; a release inserts one rectangle. Each insert scans
// the list entry by entry (read, join check), and every merge costs a shift of
// the list tail (read, write per entry) before the scan restarts from the head.
// Writing either page register resets the list to the whole page at once;
// results wait in an output register while the next transaction is taken.
module guillotine_rect_allocator_unit
    import gra_pkg::*;
#(
    parameter int MAX_FREE_RECTS = DEF_MAX_FREE_RECTS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [SIZE_BITS-1:0]    cfg_data,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [0:0]              s_axis_tuser,  // mode
    input  logic [55:0]             s_axis_tdata,  // rect_x, rect_y, req_width, req_height
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [1:0]              m_axis_tuser,  // status
    output logic [23:0]             m_axis_tdata   // origin_x, origin_y
);

    gra_cmd_t  cmd;
    gra_stat_t stat;
    rect_t     in_rect;
    coord_t    out_x;
    coord_t    out_y;

    assign in_rect = '{x: s_axis_tdata[11:0], y: s_axis_tdata[23:12],
                       w: s_axis_tdata[36:24], h: s_axis_tdata[49:37]};

    gra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gra_datapath #(
        .MAX_FREE_RECTS (MAX_FREE_RECTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg_ready  (cfg_ready),
        .in_mode    (s_axis_tuser[0]),
        .in_rect    (in_rect),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_x      (out_x),
        .out_y      (out_y)
    );

    assign m_axis_tdata = {out_y, out_x};

endmodule

FILE: sv/gra_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the allocator, attached by bind.
// Depends on gra_pkg and guillotine_rect_allocator_unit_macros.svh.
`include "guillotine_rect_allocator_unit_macros.svh"
module gra_checker
    import gra_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [1:0]  m_axis_tuser,
    input logic [23:0] m_axis_tdata
);

    // one transaction in flight: no new request right after one is taken
    `GRA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

    `GRA_ASSERT_NEVER(a_status_code, clk, rst_n, m_axis_tvalid && m_axis_tuser != STATUS_OK && m_axis_tuser != STATUS_NO_FIT && m_axis_tuser != STATUS_FULL, "undefined status code")

    // failed requests report a zero origin
    `GRA_ASSERT_NEVER(a_error_origin, clk, rst_n, m_axis_tvalid && m_axis_tuser != STATUS_OK && m_axis_tdata != '0, "nonzero origin on error")

    `GRA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind guillotine_rect_allocator_unit gra_checker u_gra_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for guillotine_rect_allocator_unit: directed table, then random
// allocate/release traffic over several page sizes, checked against an in-bench free-list model.
// Depends on gra_pkg and the allocator RTL.
module testbench;
    import gra_pkg::*;

    localparam int MAX_RECTS   = DEF_MAX_FREE_RECTS;
    localparam int IDLE_LIMIT  = 200000;
    localparam int SETTLE_CYC  = 40;

    typedef struct {
        int unsigned x, y, w, h;
    } box_t;

    typedef struct {
        logic [1:0] status;
        logic [11:0] ox, oy;
    } alloc_result_t;

    typedef struct {
        logic        mode;
        int unsigned x, y, w, h;
        bit          typed;
        status_t     status;
        int unsigned ox, oy;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [0:0]  s_axis_tuser;   // mode
    logic [55:0] s_axis_tdata;   // rect_x, rect_y, req_width, req_height
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [1:0]  m_axis_tuser;   // status
    logic [23:0] m_axis_tdata;   // origin_x, origin_y

    guillotine_rect_allocator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tuser(m_axis_tuser), .m_axis_tdata(m_axis_tdata)
    );

    always #6 clk = ~clk;

    // free-list model
    box_t          free_list[$];
    box_t          scratch[$];
    int unsigned   page_w, page_h;
    box_t          live_allocs[$];
    alloc_result_t pending_results[$];
    int            errors = 0;
    int            idle_cycles = 0;

    function automatic int unsigned clamp_page(int unsigned v);
        v = v & 13'h1FFF;
        if (v < 1) return 1;
        if (v > 4096) return 4096;
        return v;
    endfunction

    function automatic void restart_list();
        box_t whole;
        whole = '{0, 0, page_w, page_h};
        free_list.delete();
        free_list.insert(0, whole);
        live_allocs.delete();
    endfunction

    function automatic bit edge_merge(ref box_t b, input box_t e);
        if (b.y == e.y && b.h == e.h) begin
            if (b.x + b.w == e.x) begin b.w += e.w; return 1; end
            if (e.x + e.w == b.x) begin b.x = e.x; b.w += e.w; return 1; end
        end
        if (b.x == e.x && b.w == e.w) begin
            if (b.y + b.h == e.y) begin b.h += e.h; return 1; end
            if (e.y + e.h == b.y) begin b.y = e.y; b.h += e.h; return 1; end
        end
        return 0;
    endfunction

    function automatic bit merge_into_scratch(box_t b);
        bit again;
        again = 1;
        while (again) begin
            again = 0;
            for (int i = 0; i < scratch.size(); i++) begin
                if (edge_merge(b, scratch[i])) begin
                    scratch.delete(i);
                    again = 1;
                    break;
                end
            end
        end
        if (scratch.size() >= MAX_RECTS) return 0;
        scratch.insert(scratch.size(), b);
        return 1;
    endfunction

    function automatic alloc_result_t predict_item(logic mode, int unsigned rx, int unsigned ry,
                                                   int unsigned w, int unsigned h);
        alloc_result_t r;
        box_t b, box, b1, b2;
        int best;
        bit found, ok;
        longint unsigned score, best_score;
        int unsigned dx, dy;
        r = '{STATUS_OK, 0, 0};
        if (mode == MODE_RELEASE) begin
            if (w != 0 && h != 0 && rx < page_w && ry < page_h) begin
                if (w > page_w - rx) w = page_w - rx;
                if (h > page_h - ry) h = page_h - ry;
                b = '{rx, ry, w, h};
                scratch = free_list;
                if (merge_into_scratch(b)) free_list = scratch;
                else r.status = STATUS_FULL;
            end
        end else if (w == 0 || h == 0) begin
            r.status = STATUS_NO_FIT;
        end else begin
            found = 0;
            best = 0;
            best_score = 0;
            for (int i = 0; i < free_list.size(); i++) begin
                if (free_list[i].w >= w && free_list[i].h >= h) begin
                    score = longint'(free_list[i].w) * free_list[i].h - longint'(w) * h;
                    if (!found || score < best_score) begin
                        found = 1;
                        best = i;
                        best_score = score;
                    end
                    if (best_score == 0) break;
                end
            end
            if (!found) begin
                r.status = STATUS_NO_FIT;
            end else begin
                box = free_list[best];
                dx = box.w - w;
                dy = box.h - h;
                scratch = free_list;
                scratch.delete(best);
                b1 = '{box.x + w, box.y, dx, 0};
                b2 = '{box.x, box.y + h, 0, dy};
                // cut along the longer leftover axis
                if (dy < dx) begin b1.h = box.h; b2.w = w; end
                else begin b1.h = h; b2.w = box.w; end
                ok = 1;
                if (b1.w != 0 && b1.h != 0) ok = merge_into_scratch(b1);
                if (ok && b2.w != 0 && b2.h != 0) ok = merge_into_scratch(b2);
                if (ok) begin
                    free_list = scratch;
                    r.ox = box.x[11:0];
                    r.oy = box.y[11:0];
                    b = '{box.x, box.y, w, h};
                    live_allocs.insert(live_allocs.size(), b);
                end else begin
                    r.status = STATUS_FULL;
                end
            end
        end
        return r;
    endfunction

    // result checking
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d x=%0d y=%0d", $time,
                         m_axis_tuser, m_axis_tdata[11:0], m_axis_tdata[23:12]);
                errors++;
            end else begin
                alloc_result_t e;
                e = pending_results.pop_front();
                if (m_axis_tuser !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status,
                             m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[11:0] !== e.ox) begin
                    $display("%0t: origin_x expected %0d actual %0d", $time, e.ox,
                             m_axis_tdata[11:0]);
                    errors++;
                end
                if (m_axis_tdata[23:12] !== e.oy) begin
                    $display("%0t: origin_y expected %0d actual %0d", $time, e.oy,
                             m_axis_tdata[23:12]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int unsigned draw_gap();
        if ($urandom_range(0, 9) < 3) return 0;
        return $urandom_range(0, 5);
    endfunction

    // result side stalls
    initial begin
        int unsigned gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_item(logic mode, int unsigned x, int unsigned y, int unsigned w,
                             int unsigned h, bit typed = 0, alloc_result_t typed_res = '{0, 0, 0});
        int unsigned gap;
        alloc_result_t r;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {6'd0, h[12:0], w[12:0], y[11:0], x[11:0]};
        do @(posedge clk); while (!s_axis_tready);
        r = predict_item(mode, x & 12'hFFF, y & 12'hFFF, w & 13'h1FFF, h & 13'h1FFF);
        pending_results.insert(pending_results.size(), typed ? typed_res : r);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_page(logic [0:0] idx, int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[12:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_PAGE_WIDTH) page_w = clamp_page(value);
        else page_h = clamp_page(value);
        restart_list();
    endtask

    task automatic random_traffic(int count);
        int unsigned sel, w, h, x, y, k, lim_w, lim_h;
        box_t b;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            lim_w = (page_w / 4 > 0) ? page_w / 4 : 1;
            lim_h = (page_h / 4 > 0) ? page_h / 4 : 1;
            if (sel < 45) begin
                send_item(MODE_ALLOC, $urandom, $urandom, $urandom_range(1, lim_w),
                          $urandom_range(1, lim_h));
            end else if (sel < 72 && live_allocs.size() > 0) begin
                k = $urandom_range(0, live_allocs.size() - 1);
                b = live_allocs[k];
                live_allocs.delete(k);
                send_item(MODE_RELEASE, b.x, b.y, b.w, b.h);
            end else if (sel < 88) begin
                // small scattered releases fragment the list toward overflow
                x = $urandom_range(0, page_w - 1);
                y = $urandom_range(0, page_h - 1);
                send_item(MODE_RELEASE, x, y, $urandom_range(1, 3), $urandom_range(1, 3));
            end else begin
                w = $urandom_range(0, 8191);
                h = $urandom_range(0, 8191);
                if ($urandom_range(0, 1)) begin
                    w = w % 64;
                    h = h % 64;
                end
                send_item(1'($urandom_range(0, 1)), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), w, h);
            end
        end
    endtask

    row_t directed[$];

    initial begin
        int unsigned pages[7][2];
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = '0;
        s_axis_tdata  = '0;
        page_w = 1024;
        page_h = 1024;
        restart_list();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{
            '{MODE_ALLOC,   0,    0,    0,    5,    1, STATUS_NO_FIT, 0, 0},
            '{MODE_ALLOC,   0,    0,    7,    0,    1, STATUS_NO_FIT, 0, 0},
            '{MODE_ALLOC,   0,    0,    1025, 1,    1, STATUS_NO_FIT, 0, 0},
            '{MODE_ALLOC,   4095, 4095, 8191, 8191, 1, STATUS_NO_FIT, 0, 0},
            '{MODE_ALLOC,   0,    0,    1024, 1024, 1, STATUS_OK,     0, 0},
            '{MODE_ALLOC,   0,    0,    1,    1,    1, STATUS_NO_FIT, 0, 0},
            '{MODE_RELEASE, 0,    0,    1024, 1024, 1, STATUS_OK,     0, 0},
            '{MODE_RELEASE, 4095, 4095, 8191, 8191, 1, STATUS_OK,     0, 0},
            '{MODE_RELEASE, 3,    3,    0,    9,    1, STATUS_OK,     0, 0},
            '{MODE_RELEASE, 3,    3,    9,    0,    1, STATUS_OK,     0, 0},
            '{MODE_ALLOC,   0,    0,    1,    1,    1, STATUS_OK,     0, 0},
            '{MODE_ALLOC,   0,    0,    300,  20,   0, STATUS_OK,     0, 0},
            '{MODE_ALLOC,   0,    0,    20,   300,  0, STATUS_OK,     0, 0},
            '{MODE_RELEASE, 0,    0,    1,    1,    0, STATUS_OK,     0, 0},
            '{MODE_RELEASE, 1,    0,    300,  20,   0, STATUS_OK,     0, 0},
            '{MODE_RELEASE, 1000, 1000, 500,  500,  0, STATUS_OK,     0, 0},
            '{MODE_ALLOC,   0,    0,    1024, 1,    0, STATUS_OK,     0, 0},
            '{MODE_ALLOC,   0,    0,    512,  512,  0, STATUS_OK,     0, 0},
            '{MODE_ALLOC,   0,    0,    4096, 4096, 0, STATUS_OK,     0, 0},
            '{MODE_RELEASE, 2048, 17,   5,    5,    0, STATUS_OK,     0, 0},
            '{MODE_RELEASE, 0,    1023, 4096, 4096, 0, STATUS_OK,     0, 0}
        };
        foreach (directed[i])
            send_item(directed[i].mode, directed[i].x, directed[i].y, directed[i].w,
                      directed[i].h, directed[i].typed,
                      '{directed[i].status, directed[i].ox[11:0], directed[i].oy[11:0]});
        // hold off until every result is back
        drain();

        pages = '{'{1024, 1024}, '{4096, 4096}, '{1, 1}, '{0, 8191}, '{64, 48},
                  '{16, 16}, '{200, 4096}};
        foreach (pages[p]) begin
            write_page(CFG_PAGE_WIDTH, pages[p][0]);
            write_page(CFG_PAGE_HEIGHT, pages[p][1]);
            random_traffic(160);
            drain();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
